@@ design/eopt_pkg.sv @@
// Shared types and constants for the EDNS0 OPT record parser.
package eopt_pkg;

	// Default width of the buffer length and byte position counters.
	localparam int LENGTH_BITS_DEF = 16;

	// Record layout constants.
	localparam int MIN_RECORD     = 11;
	localparam int OPT_HDR_BYTES  = 4;
	localparam int OPT_TYPE       = 41;
	localparam int POS_TYPE       = 2;
	localparam int POS_PAYLOAD    = 4;
	localparam int POS_RCODE      = 5;
	localparam int POS_VERSION    = 6;
	localparam int POS_FLAGS      = 8;

	// Result kinds.
	typedef enum logic [1:0] {
		K_HEADER = 2'd0,
		K_DATA   = 2'd1,
		K_DONE   = 2'd2,
		K_ERROR  = 2'd3
	} kind_t;

	// Error codes.
	localparam logic [1:0] E_BAD_ARG   = 2'd0;
	localparam logic [1:0] E_TOO_FEW   = 2'd1;
	localparam logic [1:0] E_MALFORMED = 2'd2;

	// Parse phases, one-hot.
	typedef enum logic [5:0] {
		PH_HDR     = 6'b000001,
		PH_CODE_HI = 6'b000010,
		PH_CODE_LO = 6'b000100,
		PH_LEN_HI  = 6'b001000,
		PH_LEN_LO  = 6'b010000,
		PH_DATA    = 6'b100000
	} phase_t;

	// One result item.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] option_code;
		logic [15:0] option_length;
		logic [7:0]  option_byte;
		logic [15:0] udp_payload;
		logic [7:0]  extended_rcode;
		logic [7:0]  edns_version;
		logic [15:0] flag_bits;
		logic [15:0] consumed;
		logic [1:0]  error_code;
		logic        last_of_run;
	} result_t;

	// Results caused by one byte: up to two, in order.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} step_out_t;

endpackage

@@ design/edns_opt_record_parser_unit.sv @@
// Top level of the EDNS0 OPT record parser: stream ports, input and result registers.
// A byte waits in the input register; its results then go to the result register.
// Throughput: one byte per cycle; a byte with results stalls input while the result
// register cannot take them: it holds a pair, or holds one that is not being taken.
// Bytes that cause no result never wait for the result register.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser
// to the record start state.
module edns_opt_record_parser_unit #(
	parameter int LENGTH_BITS = eopt_pkg::LENGTH_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [23:0]   s_tdata,  // data_byte[7:0], buffer_size[23:8]
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [111:0]  m_tdata,  // option_code, option_length, option_byte, udp_payload,
	                                // extended_rcode, edns_version, flag_bits, consumed,
	                                // error_code, zero fill
	output logic [1:0]    m_tuser,  // kind
	output logic          m_tlast   // last_of_run
);

	// Input register.
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic [15:0]         size_s1;

	// Result register: head is shown, tail follows when two results are pending.
	logic [1:0]          pend_s2;
	eopt_pkg::result_t   head_s2;
	eopt_pkg::result_t   tail_s2;

	eopt_pkg::step_out_t step_out;
	logic                s2_free;
	logic                advance;
	logic                take;

	eopt_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.data_byte  (byte_s1),
		.buffer_size(size_s1),
		.step_out   (step_out)
	);

	// Handshake control.
	assign take     = m_tvalid && m_tready;
	assign s2_free  = (pend_s2 == 2'd0) || ((pend_s2 == 2'd1) && m_tready);
	assign advance  = valid_s1 && ((step_out.count == 2'd0) || s2_free);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
			size_s1 <= s_tdata[23:8];
		end
	end

	// Result register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= 2'd0;
		end else if (advance && (step_out.count != 2'd0)) begin
			pend_s2 <= step_out.count;
		end else if (take) begin
			pend_s2 <= pend_s2 - 2'd1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance && (step_out.count != 2'd0)) begin
			head_s2 <= step_out.first;
			tail_s2 <= step_out.second;
		end else if (take && (pend_s2 == 2'd2)) begin
			head_s2 <= tail_s2;
		end
	end

	// Output packing.
	assign m_tvalid = (pend_s2 != 2'd0);
	assign m_tuser  = head_s2.kind;
	assign m_tlast  = head_s2.last_of_run;
	assign m_tdata  = {6'd0, head_s2.error_code, head_s2.consumed, head_s2.flag_bits,
		head_s2.edns_version, head_s2.extended_rcode, head_s2.udp_payload,
		head_s2.option_byte, head_s2.option_length, head_s2.option_code};

	// Two pending results: the shown one is not last, the held one is.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s2 == 2'd2) |-> (!head_s2.last_of_run && tail_s2.last_of_run))
		else $error("run marks of a result pair are wrong");

	// Occupancy never exceeds two.
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_s2 != 2'd3)
		else $error("result register overfilled");

	// Taking the first of a pair leaves the second on show.
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && (pend_s2 == 2'd2)) |=> (m_tvalid && m_tlast))
		else $error("second result of a pair lost");

	// An error result carries a defined error code.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == eopt_pkg::K_ERROR)) |-> (head_s2.error_code != 2'd3))
		else $error("undefined error code");

endmodule

@@ design/eopt_core.sv @@
// Parse state and per-byte next-state logic of the EDNS0 OPT record parser.
module eopt_core #(
	parameter int LENGTH_BITS = eopt_pkg::LENGTH_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          data_byte,
	input  logic [15:0]         buffer_size,
	output eopt_pkg::step_out_t step_out
);

	localparam int LB = LENGTH_BITS;
	localparam int SW = (LB > 16) ? LB : 16;
	localparam int CW = ((LB > 17) ? LB : 17) + 1;

	// Parse state.
	logic [LB-1:0]        byte_pos_q, byte_pos_d;
	logic [LB-1:0]        buf_left_q, buf_left_d;
	logic [15:0]          rdata_len_q, rdata_len_d;
	eopt_pkg::phase_t     phase_q, phase_d;
	logic [15:0]          opt_left_q, opt_left_d;
	logic [7:0]           acc_q, acc_d;
	logic [15:0]          code_q, code_d;
	logic [15:0]          payload_q, payload_d;
	logic [7:0]           rcode_q, rcode_d;
	logic [7:0]           version_q, version_d;
	logic [15:0]          flags_q, flags_d;
	logic                 skip_q, skip_d;

	// Per-byte working signals.
	logic [LB-1:0]        size_sat;
	logic [LB-1:0]        bl_dec;
	logic [LB-1:0]        bp_inc;
	logic [15:0]          field_word;
	logic [15:0]          opt_dec;
	logic [15:0]          rd_eff;
	logic                 prim_v;
	logic                 bnd_take;
	logic                 bnd_v;
	logic                 do_finish;
	eopt_pkg::result_t    prim;
	eopt_pkg::result_t    bnd;

	// Saturate the buffer size to the counter width.
	assign size_sat = (SW'(buffer_size) > SW'({LB{1'b1}})) ? {LB{1'b1}} : LB'(buffer_size);
	assign bl_dec     = buf_left_q - LB'(1);
	assign bp_inc     = byte_pos_q + LB'(1);
	assign field_word = {acc_q, data_byte};
	assign opt_dec    = (opt_left_q != 16'd0) ? (opt_left_q - 16'd1) : 16'd0;

	// Next-state and result logic for the byte held in the input register.
	always_comb begin
		byte_pos_d  = byte_pos_q;
		buf_left_d  = buf_left_q;
		rdata_len_d = rdata_len_q;
		phase_d     = phase_q;
		opt_left_d  = opt_left_q;
		acc_d       = acc_q;
		code_d      = code_q;
		payload_d   = payload_q;
		rcode_d     = rcode_q;
		version_d   = version_q;
		flags_d     = flags_q;
		skip_d      = skip_q;
		prim_v      = 1'b0;
		prim        = '0;
		bnd_take    = 1'b0;
		bnd_v       = 1'b0;
		bnd         = '0;
		rd_eff      = rdata_len_q;
		do_finish   = 1'b0;

		if (buf_left_q == '0) begin
			// First byte of a record: owner must be the root.
			skip_d     = 1'b0;
			phase_d    = eopt_pkg::PH_HDR;
			byte_pos_d = '0;
			if (size_sat == '0) begin
				prim_v          = 1'b1;
				prim.kind       = eopt_pkg::K_ERROR;
				prim.error_code = eopt_pkg::E_BAD_ARG;
			end else begin
				buf_left_d = size_sat - LB'(1);
				if (size_sat < LB'(eopt_pkg::MIN_RECORD)) begin
					prim_v          = 1'b1;
					prim.kind       = eopt_pkg::K_ERROR;
					prim.error_code = eopt_pkg::E_TOO_FEW;
					do_finish       = 1'b1;
				end else if (data_byte != 8'd0) begin
					prim_v          = 1'b1;
					prim.kind       = eopt_pkg::K_ERROR;
					prim.error_code = eopt_pkg::E_MALFORMED;
					do_finish       = 1'b1;
				end else begin
					byte_pos_d = LB'(1);
				end
			end
		end else if (skip_q) begin
			// Drop the rest of the buffer.
			buf_left_d = bl_dec;
			if (bl_dec == '0) begin
				skip_d = 1'b0;
			end
		end else begin
			buf_left_d = bl_dec;
			byte_pos_d = bp_inc;
			unique case (phase_q)
				eopt_pkg::PH_HDR: begin
					if (byte_pos_q == LB'(eopt_pkg::POS_RCODE)) begin
						rcode_d = data_byte;
					end else if (byte_pos_q == LB'(eopt_pkg::POS_VERSION)) begin
						version_d = data_byte;
					end else if (byte_pos_q[0]) begin
						acc_d = data_byte;
					end else if (byte_pos_q == LB'(eopt_pkg::POS_TYPE)) begin
						if (field_word != 16'(eopt_pkg::OPT_TYPE)) begin
							prim_v          = 1'b1;
							prim.kind       = eopt_pkg::K_ERROR;
							prim.error_code = eopt_pkg::E_MALFORMED;
							do_finish       = 1'b1;
						end
					end else if (byte_pos_q == LB'(eopt_pkg::POS_PAYLOAD)) begin
						payload_d = field_word;
					end else if (byte_pos_q == LB'(eopt_pkg::POS_FLAGS)) begin
						flags_d = field_word;
					end else begin
						// Last byte of rdlength.
						rdata_len_d = field_word;
						rd_eff      = field_word;
						if (SW'(bl_dec) < SW'(field_word)) begin
							prim_v          = 1'b1;
							prim.kind       = eopt_pkg::K_ERROR;
							prim.error_code = eopt_pkg::E_TOO_FEW;
							do_finish       = 1'b1;
						end else begin
							bnd_take = 1'b1;
						end
					end
				end
				eopt_pkg::PH_CODE_HI: begin
					acc_d   = data_byte;
					phase_d = eopt_pkg::PH_CODE_LO;
				end
				eopt_pkg::PH_CODE_LO: begin
					code_d  = field_word;
					phase_d = eopt_pkg::PH_LEN_HI;
				end
				eopt_pkg::PH_LEN_HI: begin
					acc_d   = data_byte;
					phase_d = eopt_pkg::PH_LEN_LO;
				end
				eopt_pkg::PH_LEN_LO: begin
					if (SW'(bl_dec) < SW'(field_word)) begin
						prim_v          = 1'b1;
						prim.kind       = eopt_pkg::K_ERROR;
						prim.error_code = eopt_pkg::E_TOO_FEW;
						do_finish       = 1'b1;
					end else begin
						prim_v             = 1'b1;
						prim.kind          = eopt_pkg::K_HEADER;
						prim.option_code   = code_q;
						prim.option_length = field_word;
						if (field_word == 16'd0) begin
							bnd_take = 1'b1;
						end else begin
							opt_left_d = field_word;
							phase_d    = eopt_pkg::PH_DATA;
						end
					end
				end
				eopt_pkg::PH_DATA: begin
					prim_v           = 1'b1;
					prim.kind        = eopt_pkg::K_DATA;
					prim.option_byte = data_byte;
					opt_left_d       = opt_dec;
					if (opt_dec == 16'd0) begin
						bnd_take = 1'b1;
					end
				end
				default: begin
					phase_d = eopt_pkg::PH_HDR;
				end
			endcase
		end

		// Option boundary: record end, short header, or the next option.
		if (bnd_take) begin
			if (CW'(bp_inc) >= CW'(rd_eff) + CW'(eopt_pkg::MIN_RECORD)) begin
				bnd_v              = 1'b1;
				bnd.kind           = eopt_pkg::K_DONE;
				bnd.udp_payload    = payload_q;
				bnd.extended_rcode = rcode_q;
				bnd.edns_version   = version_q;
				bnd.flag_bits      = flags_q;
				bnd.consumed       = 16'(bp_inc);
				do_finish          = 1'b1;
			end else if (bl_dec < LB'(eopt_pkg::OPT_HDR_BYTES)) begin
				bnd_v          = 1'b1;
				bnd.kind       = eopt_pkg::K_ERROR;
				bnd.error_code = eopt_pkg::E_TOO_FEW;
				do_finish      = 1'b1;
			end else begin
				phase_d = eopt_pkg::PH_CODE_HI;
			end
		end

		// Close the record; skip whatever is left of the buffer.
		if (do_finish) begin
			phase_d    = eopt_pkg::PH_HDR;
			byte_pos_d = '0;
			opt_left_d = 16'd0;
			skip_d     = (buf_left_d != '0);
		end
	end

	// Order the results; the last one of the byte carries the run mark.
	always_comb begin
		step_out.count              = {1'b0, prim_v} + {1'b0, bnd_v};
		step_out.first              = prim_v ? prim : bnd;
		step_out.first.last_of_run  = (prim_v != bnd_v);
		step_out.second             = bnd;
		step_out.second.last_of_run = 1'b1;
	end

	// State registers advance once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q  <= '0;
			buf_left_q  <= '0;
			rdata_len_q <= '0;
			phase_q     <= eopt_pkg::PH_HDR;
			opt_left_q  <= '0;
			acc_q       <= '0;
			code_q      <= '0;
			payload_q   <= '0;
			rcode_q     <= '0;
			version_q   <= '0;
			flags_q     <= '0;
			skip_q      <= 1'b0;
		end else if (step_en) begin
			byte_pos_q  <= byte_pos_d;
			buf_left_q  <= buf_left_d;
			rdata_len_q <= rdata_len_d;
			phase_q     <= phase_d;
			opt_left_q  <= opt_left_d;
			acc_q       <= acc_d;
			code_q      <= code_d;
			payload_q   <= payload_d;
			rcode_q     <= rcode_d;
			version_q   <= version_d;
			flags_q     <= flags_d;
			skip_q      <= skip_d;
		end
	end

	// A skipped buffer always has bytes left to drop.
	assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (buf_left_q != '0))
		else $error("skip set with an empty buffer");

	// Option data is only walked with a nonzero count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == eopt_pkg::PH_DATA) |-> (opt_left_q != 16'd0))
		else $error("data phase with no option bytes left");

	// A second result is always the record end or an error.
	assert property (@(posedge clk) disable iff (!arst_n)
		(step_out.count == 2'd2) |->
		(step_out.second.kind == eopt_pkg::K_DONE || step_out.second.kind == eopt_pkg::K_ERROR))
		else $error("second result of a byte is neither done nor error");

endmodule

@@ tb/edns_opt_record_parser_checker.sv @@
`timescale 1ns / 1ps
// Checker for the OPT record parser: predicts the results of each accepted byte and compares them.
module edns_opt_record_parser_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [23:0]  s_tdata,  // data_byte[7:0], buffer_size[23:8]
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,  // option_code, option_length, option_byte, udp_payload,
	                               // extended_rcode, edns_version, flag_bits, consumed,
	                               // error_code, zero fill
	input  logic [1:0]   m_tuser,  // kind
	input  logic         m_tlast,
	output int           fail_count,
	output int           pending
);
	import eopt_pkg::*;

	// Parser state as seen from the outside.
	logic [15:0] position;
	logic [15:0] remaining;
	logic [15:0] rdata_len;
	logic [15:0] opt_left;
	logic [15:0] accum;
	logic [15:0] opt_code;
	logic [15:0] payload;
	logic [15:0] flags;
	logic [7:0]  rcode;
	logic [7:0]  version;
	logic        skipping;
	phase_t      phase;

	// Results of the byte being predicted, and all results still owed by the block.
	result_t byte_results[$];
	result_t awaited_results[$];

	function automatic void add_error(logic [1:0] code);
		result_t r;
		r = '0;
		r.kind = K_ERROR;
		r.error_code = code;
		byte_results.push_back(r);
	endfunction

	// Leave the record; the rest of the buffer, if any, is dropped.
	function automatic void close_record();
		phase = PH_HDR;
		position = '0;
		opt_left = '0;
		skipping = (remaining != 16'd0);
	endfunction

	// The byte just taken ends a segment at an option boundary.
	function automatic void end_of_segment();
		result_t r;
		if (int'(position) >= int'(rdata_len) + MIN_RECORD) begin
			r = '0;
			r.kind = K_DONE;
			r.udp_payload = payload;
			r.extended_rcode = rcode;
			r.edns_version = version;
			r.flag_bits = flags;
			r.consumed = position;
			byte_results.push_back(r);
			close_record();
		end else if (int'(remaining) < OPT_HDR_BYTES) begin
			add_error(E_TOO_FEW);
			close_record();
		end else begin
			phase = PH_CODE_HI;
		end
	endfunction

	// Advance the predicted parser by one byte and queue the results it causes.
	function automatic void parse_byte(logic [7:0] b, logic [15:0] buf_size);
		int          p;
		logic [15:0] len;
		result_t     r;
		byte_results.delete();
		if (remaining == 16'd0) begin
			skipping = 1'b0;
			phase = PH_HDR;
			position = '0;
			if (buf_size == 16'd0) begin
				add_error(E_BAD_ARG);
			end else begin
				remaining = buf_size - 16'd1;
				if (int'(buf_size) < MIN_RECORD) begin
					add_error(E_TOO_FEW);
					close_record();
				end else if (b != 8'd0) begin
					add_error(E_MALFORMED);
					close_record();
				end else begin
					position = 16'd1;
				end
			end
		end else if (skipping) begin
			remaining = remaining - 16'd1;
			if (remaining == 16'd0)
				skipping = 1'b0;
		end else begin
			p = int'(position);
			remaining = remaining - 16'd1;
			position = position + 16'd1;
			case (phase)
				PH_HDR: begin
					if (p == POS_RCODE) begin
						rcode = b;
					end else if (p == POS_VERSION) begin
						version = b;
					end else if (p % 2 == 1) begin
						accum = {8'd0, b};
					end else begin
						accum = {accum[7:0], b};
						if (p == POS_TYPE) begin
							if (int'(accum) != OPT_TYPE) begin
								add_error(E_MALFORMED);
								close_record();
							end
						end else if (p == POS_PAYLOAD) begin
							payload = accum;
						end else if (p == POS_FLAGS) begin
							flags = accum;
						end else begin
							rdata_len = accum;
							if (remaining < rdata_len) begin
								add_error(E_TOO_FEW);
								close_record();
							end else begin
								end_of_segment();
							end
						end
					end
				end
				PH_CODE_HI: begin
					accum = {8'd0, b};
					phase = PH_CODE_LO;
				end
				PH_CODE_LO: begin
					opt_code = {accum[7:0], b};
					phase = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					accum = {8'd0, b};
					phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len = {accum[7:0], b};
					if (remaining < len) begin
						add_error(E_TOO_FEW);
						close_record();
					end else begin
						r = '0;
						r.kind = K_HEADER;
						r.option_code = opt_code;
						r.option_length = len;
						byte_results.push_back(r);
						if (len == 16'd0) begin
							end_of_segment();
						end else begin
							opt_left = len;
							phase = PH_DATA;
						end
					end
				end
				default: begin
					r = '0;
					r.kind = K_DATA;
					r.option_byte = b;
					byte_results.push_back(r);
					if (opt_left != 16'd0)
						opt_left = opt_left - 16'd1;
					if (opt_left == 16'd0)
						end_of_segment();
				end
			endcase
		end
		// The last result of a byte carries the end-of-run mark.
		if (byte_results.size() > 0) begin
			r = byte_results.pop_back();
			r.last_of_run = 1'b1;
			byte_results.push_back(r);
		end
		foreach (byte_results[i])
			awaited_results.push_back(byte_results[i]);
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Compare each result transaction with the oldest expectation, then predict new bytes.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			position = '0;
			remaining = '0;
			rdata_len = '0;
			opt_left = '0;
			accum = '0;
			opt_code = '0;
			payload = '0;
			flags = '0;
			rcode = '0;
			version = '0;
			skipping = 1'b0;
			phase = PH_HDR;
			awaited_results.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got kind %0d tdata 0x%0h",
						$time, m_tuser, m_tdata);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("kind", 16'(want.kind), 16'(m_tuser));
					check_field("option_code", want.option_code, m_tdata[15:0]);
					check_field("option_length", want.option_length, m_tdata[31:16]);
					check_field("option_byte", 16'(want.option_byte), 16'(m_tdata[39:32]));
					check_field("udp_payload", want.udp_payload, m_tdata[55:40]);
					check_field("extended_rcode", 16'(want.extended_rcode), 16'(m_tdata[63:56]));
					check_field("edns_version", 16'(want.edns_version), 16'(m_tdata[71:64]));
					check_field("flag_bits", want.flag_bits, m_tdata[87:72]);
					check_field("consumed", want.consumed, m_tdata[103:88]);
					check_field("error_code", 16'(want.error_code), 16'(m_tdata[105:104]));
					check_field("last_of_run", 16'(want.last_of_run), 16'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata[7:0], s_tdata[23:8]);
			pending <= awaited_results.size();
		end
	end

endmodule

@@ tb/edns_opt_record_parser_unit_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the OPT record parser: clock, reset, record stimulus and the verdict.
module edns_opt_record_parser_unit_test;
	import eopt_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [23:0]  s_tdata = '0;  // data_byte[7:0], buffer_size[23:8]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;       // option_code, option_length, option_byte, udp_payload,
	                             // extended_rcode, edns_version, flag_bits, consumed,
	                             // error_code, zero fill
	logic [1:0]   m_tuser;       // kind
	logic         m_tlast;

	int   fail_count;
	int   pending;
	int   bytes_sent = 0;
	bit   sender_calm = 1'b0;
	bit   receiver_calm = 1'b0;
	logic [7:0] record_octets[$];

	always #1 clk = ~clk;

	edns_opt_record_parser_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	edns_opt_record_parser_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one byte and hold it until the transaction completes.
	task automatic send_byte(logic [7:0] b, logic [15:0] buf_size);
		int gap;
		gap = pick_gap(sender_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {buf_size, b};
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// Send a whole buffer: padded with random bytes or cut to its size.
	// The size is only meaningful on the first byte, so later bytes carry noise there.
	task automatic send_buffer(logic [15:0] buf_size);
		int count;
		logic [7:0] b;
		count = (buf_size == 16'd0) ? 1 : int'(buf_size);
		for (int i = 0; i < count; i++) begin
			b = (i < record_octets.size()) ? record_octets[i] : 8'($urandom);
			send_byte(b, (i == 0) ? buf_size : 16'($urandom));
		end
	endtask

	// Stop offering bytes until the block has delivered everything owed.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Build a record, well formed or with one flaw, and return its buffer size.
	function automatic logic [15:0] build_record();
		int n_opts, len, rdlen, flaw, idx, r;
		int opt_starts[$];
		logic [15:0] buf_size;
		logic [15:0] field;
		record_octets.delete();
		record_octets.push_back(8'h00);
		record_octets.push_back(8'h00);
		record_octets.push_back(8'(OPT_TYPE));
		for (int i = 0; i < 8; i++)
			record_octets.push_back(8'($urandom));
		n_opts = $urandom_range(0, 3);
		for (int k = 0; k < n_opts; k++) begin
			r = $urandom_range(0, 99);
			len = (r < 80) ? $urandom_range(0, 4) :
				(r < 95) ? $urandom_range(5, 12) : $urandom_range(13, 40);
			opt_starts.push_back(record_octets.size());
			record_octets.push_back(8'($urandom));
			record_octets.push_back(8'($urandom));
			record_octets.push_back(8'(len >> 8));
			record_octets.push_back(8'(len));
			for (int j = 0; j < len; j++)
				record_octets.push_back(8'($urandom));
		end
		rdlen = record_octets.size() - MIN_RECORD;
		record_octets[9] = 8'(rdlen >> 8);
		record_octets[10] = 8'(rdlen);
		buf_size = 16'(record_octets.size() + $urandom_range(0, 3));

		flaw = $urandom_range(0, 12);
		case (flaw)
			5: record_octets[0] = 8'($urandom_range(1, 255));
			6: begin
				idx = $urandom_range(1, 2);
				record_octets[idx] = record_octets[idx] ^ 8'($urandom_range(1, 255));
			end
			7: buf_size = 16'($urandom_range(1, MIN_RECORD - 1));
			8: buf_size = 16'd0;
			9: begin
				// Longer rdlength runs into the buffer end; shorter lets an option overrun it.
				r = $urandom_range(0, 2);
				field = (r == 0) ? 16'(rdlen + $urandom_range(1, 6)) :
					(r == 1 && rdlen > 0) ? 16'(rdlen - $urandom_range(1, rdlen)) :
					16'($urandom);
				record_octets[9] = field[15:8];
				record_octets[10] = field[7:0];
			end
			10: if (record_octets.size() > MIN_RECORD)
				buf_size = 16'($urandom_range(MIN_RECORD, record_octets.size()));
			11: if (opt_starts.size() > 0) begin
				idx = opt_starts[$urandom_range(0, opt_starts.size() - 1)];
				record_octets[idx + 2] = 8'($urandom);
				record_octets[idx + 3] = 8'($urandom);
			end
			12: foreach (record_octets[i])
				record_octets[i] = 8'($urandom);
			default: ;
		endcase
		return buf_size;
	endfunction

	// Receiver: stalls of random length between bursts of readiness.
	initial begin
		int stall, burst;
		@(posedge arst_n);
		forever begin
			receiver_calm = ($urandom_range(0, 7) == 0);
			stall = pick_gap(receiver_calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			burst = receiver_calm ? $urandom_range(20, 60) : $urandom_range(1, 6);
			repeat (burst) @(posedge clk);
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [15:0] buf_size;
		bit paused;
		paused = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero buffer size is a bad argument.
		record_octets.delete();
		send_buffer(16'd0);

		// Non-root owner at the minimum record size.
		record_octets = '{8'h80};
		send_buffer(16'(MIN_RECORD));

		// Extreme header fields, an all-ones option and an empty option.
		record_octets = '{8'h00, 8'h00, 8'h29, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h00, 8'h09, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
		send_buffer(16'd20);

		// Random records, with one full drain part way through.
		while (bytes_sent < 600) begin
			sender_calm = ($urandom_range(0, 3) == 0);
			buf_size = build_record();
			send_buffer(buf_size);
			if (!paused && bytes_sent >= 300) begin
				paused = 1'b1;
				drain();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
